// ----- rtl/ffad_pkg.sv -----
package ffad_pkg;

  localparam int MEM_UNITS_DEF  = 128;
  localparam int MAX_BLOCKS_DEF = 128;
  localparam int ID_WIDTH_DEF   = 16;

  localparam logic [7:0] MEM_SIZE_RST = 8'd128;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_ERASE  = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // control part of the wave that walks the cell row
  typedef struct packed {
    logic tok;  // this cell is being visited
    logic hit;  // block placed (alloc) or identifier found (erase)
  } wave_ctl_t;

endpackage

// ----- rtl/first_fit_allocator_defrag.sv -----
// Flow: an alloc refused up front (zero length, table full, identifiers used up) goes
// straight to S_DONE; every other alloc, erase or defrag walks the cell row one cell per clock in S_SWEEP
// and then passes to S_DONE, where any result is registered once the output is free.
// Only one command is taken at a time (in_tready is high only in S_IDLE); an unused command
// is taken and dropped in S_IDLE, and a result that waits for out_tready holds S_DONE.
// Reset (synchronous, active low): cell valid bits clear, id counter zero, memory_size 128.
module first_fit_allocator_defrag #(
  parameter int MEM_UNITS  = ffad_pkg::MEM_UNITS_DEF,
  parameter int MAX_BLOCKS = ffad_pkg::MAX_BLOCKS_DEF,
  parameter int ID_WIDTH   = ffad_pkg::ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[1:0], operand_value[17:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], block_id[17:2], zero pad
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW  = $clog2(MEM_UNITS + 1);
  localparam int IDW = ID_WIDTH;
  localparam int MW  = (AW > 8) ? AW : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t          state_r;
  ffad_pkg::op_t   op_r;
  logic [15:0]     opnd_r;
  logic [IDW-1:0]  next_ident_r;
  logic [IDW-1:0]  new_id_r;
  logic [7:0]      mem_size_r;
  logic            launch_r;
  logic            res_need_r;
  logic [1:0]      res_status_r;
  logic [15:0]     res_id_r;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [15:0]     out_id_r;

  ffad_pkg::wave_ctl_t wctl [MAX_BLOCKS+1];
  logic [AW-1:0]       wpl  [MAX_BLOCKS+1];
  logic                whv  [MAX_BLOCKS+1];
  logic [IDW-1:0]      whid [MAX_BLOCKS+1];
  logic [AW-1:0]       whf  [MAX_BLOCKS+1];
  logic [AW-1:0]       whl  [MAX_BLOCKS+1];
  logic                ev   [MAX_BLOCKS+1];
  logic [IDW-1:0]      eid  [MAX_BLOCKS+1];
  logic [AW-1:0]       ef   [MAX_BLOCKS+1];
  logic [AW-1:0]       el   [MAX_BLOCKS+1];

  logic [AW-1:0]  size;
  ffad_pkg::op_t  in_op;
  logic [15:0]    in_opnd;
  logic           in_xfer;
  logic           table_full;
  logic           ids_spent;
  logic           out_free;

  assign size = (MW'(mem_size_r) > MW'(MEM_UNITS)) ? AW'(MEM_UNITS) : AW'(mem_size_r);

  assign in_op      = ffad_pkg::op_t'(in_tdata[1:0]);
  assign in_opnd    = in_tdata[17:2];
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign table_full = ev[MAX_BLOCKS-1];
  assign ids_spent  = (next_ident_r == {IDW{1'b1}});
  assign out_free   = !out_valid_r || out_tready;

  // wave source and the empty neighbor above the top cell
  assign wctl[0]          = '{tok: launch_r, hit: 1'b0};
  assign wpl[0]           = '0;
  assign whv[0]           = 1'b0;
  assign whid[0]          = '0;
  assign whf[0]           = '0;
  assign whl[0]           = '0;
  assign ev[MAX_BLOCKS]   = 1'b0;
  assign eid[MAX_BLOCKS]  = '0;
  assign ef[MAX_BLOCKS]   = '0;
  assign el[MAX_BLOCKS]   = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffad_cell #(
      .AW  (AW),
      .IDW (IDW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op_i     (op_r),
      .opnd_i   (opnd_r),
      .new_id_i (new_id_r),
      .size_i   (size),
      .wctl_i   (wctl[k]),
      .pl_i     (wpl[k]),
      .hv_i     (whv[k]),
      .hid_i    (whid[k]),
      .hf_i     (whf[k]),
      .hl_i     (whl[k]),
      .wctl_o   (wctl[k+1]),
      .pl_o     (wpl[k+1]),
      .hv_o     (whv[k+1]),
      .hid_o    (whid[k+1]),
      .hf_o     (whf[k+1]),
      .hl_o     (whl[k+1]),
      .nv_i     (ev[k+1]),
      .nid_i    (eid[k+1]),
      .nf_i     (ef[k+1]),
      .nl_i     (el[k+1]),
      .v_o      (ev[k]),
      .id_o     (eid[k]),
      .f_o      (ef[k]),
      .l_o      (el[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_ident_r <= '0;
      mem_size_r   <= ffad_pkg::MEM_SIZE_RST;
      launch_r     <= 1'b0;
      res_need_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      if (cfg_we) begin
        mem_size_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r     <= in_op;
            opnd_r   <= in_opnd;
            new_id_r <= next_ident_r + IDW'(1);
            unique case (in_op)
              ffad_pkg::OP_ALLOC: begin
                if (in_opnd == 16'd0 || table_full || ids_spent) begin
                  res_need_r   <= 1'b1;
                  res_status_r <= ffad_pkg::ST_NULL;
                  res_id_r     <= 16'd0;
                  state_r      <= S_DONE;
                end else begin
                  launch_r <= 1'b1;
                  state_r  <= S_SWEEP;
                end
              end
              ffad_pkg::OP_ERASE, ffad_pkg::OP_DEFRAG: begin
                launch_r <= 1'b1;
                state_r  <= S_SWEEP;
              end
              ffad_pkg::OP_NONE: begin
                state_r <= S_IDLE;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          // wave has left the top cell: the table is final
          if (wctl[MAX_BLOCKS].tok) begin
            state_r <= S_DONE;
            unique case (op_r)
              ffad_pkg::OP_ALLOC: begin
                res_need_r <= 1'b1;
                if (wctl[MAX_BLOCKS].hit) begin
                  res_status_r <= ffad_pkg::ST_OK;
                  res_id_r     <= 16'(new_id_r);
                  next_ident_r <= new_id_r;
                end else begin
                  res_status_r <= ffad_pkg::ST_NULL;
                  res_id_r     <= 16'd0;
                end
              end
              ffad_pkg::OP_ERASE: begin
                res_need_r   <= !wctl[MAX_BLOCKS].hit;
                res_status_r <= ffad_pkg::ST_ILLEGAL;
                res_id_r     <= 16'd0;
              end
              ffad_pkg::OP_DEFRAG, ffad_pkg::OP_NONE: begin
                res_need_r <= 1'b0;
              end
              default: begin
                res_need_r <= 1'b0;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!res_need_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            res_need_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_id_r, out_status_r};

endmodule

// ----- rtl/ffad_cell.sv -----
module ffad_cell #(
  parameter int AW  = 8,
  parameter int IDW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffad_pkg::op_t      op_i,
  input  logic [15:0]        opnd_i,
  input  logic [IDW-1:0]     new_id_i,
  input  logic [AW-1:0]      size_i,
  input  ffad_pkg::wave_ctl_t wctl_i,
  input  logic [AW-1:0]      pl_i,
  input  logic               hv_i,
  input  logic [IDW-1:0]     hid_i,
  input  logic [AW-1:0]      hf_i,
  input  logic [AW-1:0]      hl_i,
  output ffad_pkg::wave_ctl_t wctl_o,
  output logic [AW-1:0]      pl_o,
  output logic               hv_o,
  output logic [IDW-1:0]     hid_o,
  output logic [AW-1:0]      hf_o,
  output logic [AW-1:0]      hl_o,
  input  logic               nv_i,
  input  logic [IDW-1:0]     nid_i,
  input  logic [AW-1:0]      nf_i,
  input  logic [AW-1:0]      nl_i,
  output logic               v_o,
  output logic [IDW-1:0]     id_o,
  output logic [AW-1:0]      f_o,
  output logic [AW-1:0]      l_o
);

  localparam int SW = ((AW > 16) ? AW : 16) + 1;
  localparam int EW = (IDW > 16) ? IDW : 16;

  logic                v_r, v_nxt;
  logic [IDW-1:0]      id_r, id_nxt;
  logic [AW-1:0]       f_r, f_nxt;
  logic [AW-1:0]       l_r, l_nxt;
  ffad_pkg::wave_ctl_t wctl_r, wctl_nxt;
  logic [AW-1:0]       pl_r, pl_nxt;
  logic                hv_r, hv_nxt;
  logic [IDW-1:0]      hid_r, hid_nxt;
  logic [AW-1:0]       hf_r, hf_nxt;
  logic [AW-1:0]       hl_r, hl_nxt;

  logic [SW-1:0] end_sum;
  logic          fit_mid;
  logic          fit_tail;
  logic [AW-1:0] new_first;
  logic [AW-1:0] new_last;
  logic [AW-1:0] dfr_last;
  logic          id_match;

  assign end_sum   = SW'(pl_i) + SW'(opnd_i);
  assign fit_mid   = SW'(f_r) > end_sum;
  assign fit_tail  = SW'(size_i) >= end_sum;
  assign new_first = pl_i + AW'(1);
  assign new_last  = end_sum[AW-1:0];
  assign dfr_last  = new_first + (l_r - f_r);
  assign id_match  = EW'(id_r) == EW'(opnd_i);

  always_comb begin
    v_nxt    = v_r;
    id_nxt   = id_r;
    f_nxt    = f_r;
    l_nxt    = l_r;
    wctl_nxt = wctl_i;
    pl_nxt   = pl_i;
    hv_nxt   = hv_i;
    hid_nxt  = hid_i;
    hf_nxt   = hf_i;
    hl_nxt   = hl_i;
    if (wctl_i.tok) begin
      unique case (op_i)
        ffad_pkg::OP_ALLOC: begin
          if (wctl_i.hit) begin
            // ripple the displaced entry one cell up
            v_nxt   = hv_i;
            id_nxt  = hid_i;
            f_nxt   = hf_i;
            l_nxt   = hl_i;
            hv_nxt  = v_r;
            hid_nxt = id_r;
            hf_nxt  = f_r;
            hl_nxt  = l_r;
          end else if ((v_r && fit_mid) || (!v_r && fit_tail)) begin
            v_nxt        = 1'b1;
            id_nxt       = new_id_i;
            f_nxt        = new_first;
            l_nxt        = new_last;
            hv_nxt       = v_r;
            hid_nxt      = id_r;
            hf_nxt       = f_r;
            hl_nxt       = l_r;
            wctl_nxt.hit = 1'b1;
          end else if (v_r) begin
            pl_nxt = l_r;
          end
        end
        ffad_pkg::OP_ERASE: begin
          // pull the upper neighbor down from the erased entry on
          if (wctl_i.hit || (v_r && id_match)) begin
            v_nxt        = nv_i;
            id_nxt       = nid_i;
            f_nxt        = nf_i;
            l_nxt        = nl_i;
            wctl_nxt.hit = 1'b1;
          end
        end
        ffad_pkg::OP_DEFRAG: begin
          if (v_r) begin
            f_nxt  = new_first;
            l_nxt  = dfr_last;
            pl_nxt = dfr_last;
          end
        end
        ffad_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      wctl_r <= '0;
    end else begin
      v_r    <= v_nxt;
      wctl_r <= wctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    f_r   <= f_nxt;
    l_r   <= l_nxt;
    pl_r  <= pl_nxt;
    hv_r  <= hv_nxt;
    hid_r <= hid_nxt;
    hf_r  <= hf_nxt;
    hl_r  <= hl_nxt;
  end

  assign wctl_o = wctl_r;
  assign pl_o   = pl_r;
  assign hv_o   = hv_r;
  assign hid_o  = hid_r;
  assign hf_o   = hf_r;
  assign hl_o   = hl_r;
  assign v_o    = v_r;
  assign id_o   = id_r;
  assign f_o    = f_r;
  assign l_o    = l_r;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ID_LIMIT     = (1 << ffad_pkg::ID_WIDTH_DEF) - 1;
  localparam int          SETTLE_CYCLES = ffad_pkg::MAX_BLOCKS_DEF + 72;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          RANDOM_ITEMS  = 500;  // per random phase

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_id;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // command[1:0], operand_value[17:2], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // status[1:0], block_id[17:2], zero pad
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // shadow of the allocation table
  logic [15:0] blk_id    [ffad_pkg::MAX_BLOCKS_DEF];
  int unsigned blk_first [ffad_pkg::MAX_BLOCKS_DEF];
  int unsigned blk_last  [ffad_pkg::MAX_BLOCKS_DEF];
  int unsigned blk_count = 0;
  int unsigned last_ident = 0;
  logic [7:0]  mem_size_cfg = ffad_pkg::MEM_SIZE_RST;

  alloc_result_t pending_results[$];
  int mismatch_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  first_fit_allocator_defrag u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow table; returns 1 when it yields a result.
  function automatic bit apply_command(input ffad_pkg::op_t cmd, input logic [15:0] opnd,
                                       output alloc_result_t res);
    int unsigned size, prev, slot, gap, span, pos, k;
    bit has;
    res.status   = ffad_pkg::ST_OK;
    res.block_id = '0;
    has = 1'b0;
    size = (mem_size_cfg > ffad_pkg::MEM_UNITS_DEF) ? ffad_pkg::MEM_UNITS_DEF : mem_size_cfg;
    case (cmd)
      ffad_pkg::OP_ALLOC: begin
        has = 1'b1;
        if (opnd == 0 || blk_count >= ffad_pkg::MAX_BLOCKS_DEF || last_ident >= ID_LIMIT) begin
          res.status = ffad_pkg::ST_NULL;
        end else begin
          slot = blk_count + 1;
          prev = 0;
          // lowest gap between blocks first, then the tail
          for (k = 0; k < blk_count && slot > blk_count; k++) begin
            gap = (blk_first[k] > prev) ? blk_first[k] - prev - 1 : 0;
            if (gap >= opnd) slot = k;
            else prev = blk_last[k];
          end
          if (slot > blk_count && size > prev && size - prev >= opnd) slot = blk_count;
          if (slot > blk_count) begin
            res.status = ffad_pkg::ST_NULL;
          end else begin
            for (k = blk_count; k > slot; k--) begin
              blk_id[k]    = blk_id[k-1];
              blk_first[k] = blk_first[k-1];
              blk_last[k]  = blk_last[k-1];
            end
            last_ident++;
            blk_id[slot]    = last_ident[15:0];
            blk_first[slot] = prev + 1;
            blk_last[slot]  = prev + opnd;
            blk_count++;
            res.block_id = last_ident[15:0];
          end
        end
      end
      ffad_pkg::OP_ERASE: begin
        pos = blk_count;
        for (k = 0; k < blk_count && pos == blk_count; k++)
          if (blk_id[k] == opnd) pos = k;
        if (pos == blk_count) begin
          has = 1'b1;
          res.status = ffad_pkg::ST_ILLEGAL;
        end else begin
          for (k = pos; k + 1 < blk_count; k++) begin
            blk_id[k]    = blk_id[k+1];
            blk_first[k] = blk_first[k+1];
            blk_last[k]  = blk_last[k+1];
          end
          blk_count--;
        end
      end
      ffad_pkg::OP_DEFRAG: begin
        prev = 0;
        for (k = 0; k < blk_count; k++) begin
          span = blk_last[k] - blk_first[k];
          blk_first[k] = prev + 1;
          blk_last[k]  = prev + 1 + span;
          prev = blk_last[k];
        end
      end
      default: ;
    endcase
    return has;
  endfunction

  // Offer one command, hold until the transfer, then record what it must produce.
  task automatic send_cmd(input ffad_pkg::op_t cmd, input logic [15:0] opnd);
    alloc_result_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, opnd, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (apply_command(cmd, opnd, res)) pending_results = {pending_results, res};
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mem_size(input logic [7:0] units);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= units;
    @(posedge clk);
    cfg_we <= 1'b0;
    mem_size_cfg = units;
  endtask

  task automatic clear_table();
    while (blk_count != 0) send_cmd(ffad_pkg::OP_ERASE, blk_id[0]);
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    send_cmd(ffad_pkg::OP_ALLOC, 16'd0);        // zero length
    send_cmd(ffad_pkg::OP_ALLOC, 16'hFFFF);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd128);      // takes the whole memory
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_ERASE, 16'd0);
    send_cmd(ffad_pkg::OP_ERASE, 16'hFFFF);
    send_cmd(ffad_pkg::OP_ERASE, 16'd1);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd10);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd20);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd5);
    send_cmd(ffad_pkg::OP_ERASE, 16'd3);        // leaves a hole at 11..30
    send_cmd(ffad_pkg::OP_ALLOC, 16'd25);       // too long for the hole, goes to the tail
    send_cmd(ffad_pkg::OP_DEFRAG, 16'hA5A5);
    send_cmd(ffad_pkg::OP_NONE, 16'h5A5A);      // ignored
    send_cmd(ffad_pkg::OP_ALLOC, 16'd30);
    send_cmd(ffad_pkg::OP_ERASE, 16'd2);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd10);       // lands in the freed hole at the bottom
    send_cmd(ffad_pkg::OP_ERASE, 16'd2);        // already gone
    send_cmd(ffad_pkg::OP_ALLOC, 16'hAAAA);
    send_cmd(ffad_pkg::OP_ALLOC, 16'h5555);
    send_cmd(ffad_pkg::OP_DEFRAG, 16'd0);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd128);
  endtask

  task automatic test_memory_size();
    clear_table();
    set_mem_size(8'd128);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd50);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd50);
    set_mem_size(8'd20);              // shrink under existing blocks
    send_cmd(ffad_pkg::OP_ALLOC, 16'd5);
    send_cmd(ffad_pkg::OP_ERASE, blk_id[0]);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd5);
    set_mem_size(8'd0);               // no room, but inner gaps remain
    send_cmd(ffad_pkg::OP_ALLOC, 16'd40);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_DEFRAG, 16'd0);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    set_mem_size(8'd255);             // clamps to the full memory
    send_cmd(ffad_pkg::OP_ALLOC, 16'd128);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd20);
    clear_table();
    set_mem_size(8'd1);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd2);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
  endtask

  task automatic test_table_full();
    int i;
    clear_table();
    set_mem_size(8'd128);
    gap_pct = 19;
    stall_pct = 19;
    for (i = 0; i < ffad_pkg::MAX_BLOCKS_DEF; i++) send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);        // table full
    send_cmd(ffad_pkg::OP_ERASE, blk_id[ffad_pkg::MAX_BLOCKS_DEF/2]);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd2);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_ALLOC, 16'd1);
    send_cmd(ffad_pkg::OP_DEFRAG, 16'd0);
    clear_table();
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    gap_pct = 0;
    stall_pct = 0;
    hold_req = HOLD_CYCLES;
    // keep offering while results are held back
    for (i = 0; i < 12; i++) begin
      if (i % 4 == 3) send_cmd(ffad_pkg::OP_ERASE, 16'hFFFF);
      else send_cmd(ffad_pkg::OP_ALLOC, 16'd3);
    end
    wait_idle();
  endtask

  task automatic send_random_cmd(output bit counted);
    int r;
    logic [15:0] len;
    r = $urandom_range(99);
    counted = 1'b1;
    if (r < 50) begin
      case ($urandom_range(19))
        0:       len = 16'd0;
        1, 2:    len = 16'($urandom);
        3, 4:    len = 16'($urandom_range(1, ffad_pkg::MEM_UNITS_DEF));
        default: len = 16'($urandom_range(1, 12));
      endcase
      send_cmd(ffad_pkg::OP_ALLOC, len);
    end else if (r < 75 && blk_count != 0) begin
      send_cmd(ffad_pkg::OP_ERASE, blk_id[$urandom_range(blk_count - 1)]);
    end else if (r < 85) begin
      send_cmd(ffad_pkg::OP_ERASE, 16'($urandom));
    end else if (r < 96) begin
      send_cmd(ffad_pkg::OP_DEFRAG, 16'($urandom));
    end else begin
      send_cmd(ffad_pkg::OP_NONE, 16'($urandom));
      counted = 1'b0;
    end
  endtask

  task automatic test_random();
    int phase, n;
    bit counted;
    logic [7:0] sizes [4];
    int gaps [4];
    int stalls [4];
    sizes  = '{8'd128, 8'($urandom_range(2, 127)), 8'd255, 8'd96};
    gaps   = '{0, 54, 0, 19};
    stalls = '{0, 0, 54, 19};
    for (phase = 0; phase < 4; phase++) begin
      set_mem_size(sizes[phase]);
      gap_pct = gaps[phase];
      stall_pct = stalls[phase];
      n = 0;
      while (n < RANDOM_ITEMS) begin
        send_random_cmd(counted);
        if (counted) n++;
      end
    end
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[1:0];
      got.block_id = out_tdata[17:2];
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status %0d id %0d", got.status, got.block_id);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.block_id !== want.block_id) begin
          if (mismatch_count < 10)
            $display("mismatch: expected status %0d id %0d, got status %0d id %0d",
                     want.status, want.block_id, got.status, got.block_id);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("first_fit_allocator_defrag test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_memory_size();
    test_table_full();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatch_count == 0)
      $display("first_fit_allocator_defrag test passed");
    else
      $display("first_fit_allocator_defrag test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ffad_pkg.sv
rtl/ffad_cell.sv
rtl/first_fit_allocator_defrag.sv
sim/tb.sv
